// ===== hw/rtl/ctm_pkg.sv =====
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and tables for the cosine table modulator
// Mode codes, the per-item state bundle and the 128-entry cosine ROM.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int unsigned PhaseW   = 7;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned WaveW    = 8;
  localparam int unsigned BitsW    = 4;
  localparam int unsigned RomDepth = 128;

  localparam logic [WaveW-1:0]   WaveMid    = 8'd128;
  localparam logic [WaveW-1:0]   AmOffset   = 8'd127;
  localparam logic [PhaseW:0]    FskStepOne = 8'd12;
  localparam logic [PhaseW:0]    FskStepZro = 8'd1;
  localparam logic [BitsW-1:0]   BitsPerByte = 4'd8;

  typedef enum logic [1:0] {
    MODE_AM  = 2'd0,
    MODE_FM  = 2'd1,
    MODE_ASK = 2'd2,
    MODE_FSK = 2'd3
  } mode_e;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [SampleW-1:0] data_bits;
    logic [BitsW-1:0]   bits_left;
  } ctm_state_t;

  typedef struct packed {
    logic [WaveW-1:0] wave;
    logic             byte_taken;
  } ctm_result_t;

  localparam logic [WaveW-1:0] CosRom [RomDepth] = '{
    8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd246,
    8'd244, 8'd241, 8'd238, 8'd235, 8'd231, 8'd228, 8'd224, 8'd220,
    8'd216, 8'd211, 8'd207, 8'd202, 8'd197, 8'd192, 8'd187, 8'd181,
    8'd176, 8'd170, 8'd165, 8'd159, 8'd153, 8'd147, 8'd141, 8'd135,
    8'd129, 8'd123, 8'd117, 8'd111, 8'd105, 8'd99,  8'd93,  8'd87,
    8'd82,  8'd76,  8'd71,  8'd66,  8'd61,  8'd56,  8'd52,  8'd47,
    8'd43,  8'd39,  8'd36,  8'd32,  8'd29,  8'd26,  8'd24,  8'd21,
    8'd19,  8'd17,  8'd16,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,
    8'd11,  8'd11,  8'd12,  8'd12,  8'd13,  8'd14,  8'd16,  8'd17,
    8'd19,  8'd21,  8'd24,  8'd26,  8'd29,  8'd32,  8'd36,  8'd39,
    8'd43,  8'd47,  8'd52,  8'd56,  8'd61,  8'd66,  8'd71,  8'd76,
    8'd82,  8'd87,  8'd93,  8'd99,  8'd105, 8'd111, 8'd117, 8'd123,
    8'd129, 8'd135, 8'd141, 8'd147, 8'd153, 8'd159, 8'd165, 8'd170,
    8'd176, 8'd181, 8'd187, 8'd192, 8'd197, 8'd202, 8'd207, 8'd211,
    8'd216, 8'd220, 8'd224, 8'd228, 8'd231, 8'd235, 8'd238, 8'd241,
    8'd244, 8'd246, 8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254
  };

endpackage

// ===== hw/rtl/ctm_step.sv =====
// ----------------------------------------------------------------------------
// ctm_step: one modulator step
// Computes the output sample and the next phase/data state for one request.
// ----------------------------------------------------------------------------
module ctm_step
  import ctm_pkg::*;
(
  input  mode_e               mode_i,
  input  ctm_state_t          state_i,
  input  logic [SampleW-1:0]  sample_i,
  output ctm_state_t          state_o,
  output ctm_result_t         result_o
);

  logic                 load;
  logic [SampleW-1:0]   data_eff;
  logic [BitsW-1:0]     bits_eff;
  logic [WaveW-1:0]     cos_cur;
  logic [WaveW-1:0]     cos_fm;
  logic [WaveW-1:0]     cos_fsk;
  logic signed [8:0]    cos_centered;
  logic signed [17:0]   am_prod;
  logic signed [17:0]   am_shift;
  logic [PhaseW:0]      inc_sum;
  logic [PhaseW:0]      fm_sum;
  logic [PhaseW:0]      fsk_sum;
  logic [SampleW-1:0]   data_shift;
  logic [BitsW-1:0]     bits_dec;

  // load a new byte once the previous one has gone out
  assign load     = (state_i.bits_left == '0);
  assign data_eff = load ? sample_i : state_i.data_bits;
  assign bits_eff = load ? BitsPerByte : state_i.bits_left;

  assign cos_cur      = CosRom[state_i.phase];
  assign cos_centered = $signed({1'b0, cos_cur}) - 9'sd128;
  assign am_prod      = $signed({1'b0, sample_i}) * cos_centered;
  assign am_shift     = am_prod >>> 8;

  assign inc_sum = {1'b0, state_i.phase} + 8'd1;
  assign fm_sum  = {1'b0, state_i.phase} + 8'd1 + {6'd0, sample_i[7:6]};
  assign fsk_sum = {1'b0, state_i.phase} + (data_eff[0] ? FskStepOne : FskStepZro);

  assign cos_fm  = CosRom[fm_sum[PhaseW-1:0]];
  assign cos_fsk = CosRom[fsk_sum[PhaseW-1:0]];

  assign data_shift = data_eff >> 1;
  assign bits_dec   = (bits_eff != '0) ? bits_eff - 4'd1 : bits_eff;

  always_comb begin
    state_o             = state_i;
    result_o.wave       = '0;
    result_o.byte_taken = 1'b0;
    unique case (mode_i)
      MODE_AM: begin
        result_o.wave = am_shift[WaveW-1:0] + AmOffset;
        state_o.phase = inc_sum[PhaseW-1:0];
      end
      MODE_FM: begin
        result_o.wave = cos_fm;
        state_o.phase = fm_sum[PhaseW-1:0];
      end
      MODE_ASK: begin
        result_o.byte_taken = load;
        result_o.wave       = data_eff[0] ? cos_cur : WaveMid;
        state_o.phase       = inc_sum[PhaseW-1:0];
        // advance to the next bit on a phase wrap
        state_o.data_bits   = inc_sum[PhaseW] ? data_shift : data_eff;
        state_o.bits_left   = inc_sum[PhaseW] ? bits_dec : bits_eff;
      end
      MODE_FSK: begin
        result_o.byte_taken = load;
        result_o.wave       = cos_fsk;
        state_o.phase       = fsk_sum[PhaseW-1:0];
        state_o.data_bits   = fsk_sum[PhaseW] ? data_shift : data_eff;
        state_o.bits_left   = fsk_sum[PhaseW] ? bits_dec : bits_eff;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cosine_table_modulator_core.sv =====
// ----------------------------------------------------------------------------
// cosine_table_modulator_core: AM/FM/ASK/FSK lookup-table modulator
// One 8-bit sample in, one 8-bit waveform sample out, from a cosine ROM.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall_o is low. The whole step (one ROM
// read, one 9x9 multiply, phase add) runs in the cycle a request is accepted,
// into the result or skid register; the phase and the ASK/FSK data byte live
// in flip-flops, so consecutive requests chain without bubbles. A one-entry
// skid register behind the result register lets a request be accepted while
// the previous result is stalled; in_stall_o rises only when both are full.
// Write the mode register only while idle.
module cosine_table_modulator_core
  import ctm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WaveW-1:0]   wave_o,
  output logic               byte_taken_o
);

  mode_e       mode_q;
  ctm_state_t  state_q, state_d;
  ctm_result_t res_new;
  ctm_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_accept, out_take;

  ctm_step u_step (
    .mode_i   (mode_q),
    .state_i  (state_q),
    .sample_i (sample_i),
    .state_o  (state_d),
    .result_o (res_new)
  );

  assign in_stall_o   = skid_valid_q;
  assign in_accept    = in_valid_i && !skid_valid_q;
  assign out_take     = out_valid_q && !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign wave_o       = out_q.wave;
  assign byte_taken_o = out_q.byte_taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AM;
      state_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: drain skid first, then take new results
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_bits_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bits_left <= BitsPerByte)
    else $error("bit counter beyond one byte");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !out_valid_q) |=> out_valid_o)
    else $error("accepted request did not reach the output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_take) |=> (out_valid_q && !skid_valid_q))
    else $error("skid did not move into the output register");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for cosine_table_modulator_core
// Drives AM, FM, ASK and FSK sample streams through the valid/stall ports,
// predicts every waveform sample and data-byte load from a local model of the
// phase, data byte and bit counter, and compares each result in order.
// ----------------------------------------------------------------------------
module tb;
  import ctm_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_wdata_i = MODE_AM;
  logic       in_valid_i  = 1'b0;
  logic [7:0] sample_i    = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] wave_o;
  logic       byte_taken_o;

  cosine_table_modulator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .wave_o       (wave_o),
    .byte_taken_o (byte_taken_o)
  );

  always #6 clk_i = ~clk_i;

  // Carrier table, kept separate from the design's copy.
  localparam logic [7:0] CosTable [128] = '{
    8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd246,
    8'd244, 8'd241, 8'd238, 8'd235, 8'd231, 8'd228, 8'd224, 8'd220,
    8'd216, 8'd211, 8'd207, 8'd202, 8'd197, 8'd192, 8'd187, 8'd181,
    8'd176, 8'd170, 8'd165, 8'd159, 8'd153, 8'd147, 8'd141, 8'd135,
    8'd129, 8'd123, 8'd117, 8'd111, 8'd105, 8'd99,  8'd93,  8'd87,
    8'd82,  8'd76,  8'd71,  8'd66,  8'd61,  8'd56,  8'd52,  8'd47,
    8'd43,  8'd39,  8'd36,  8'd32,  8'd29,  8'd26,  8'd24,  8'd21,
    8'd19,  8'd17,  8'd16,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,
    8'd11,  8'd11,  8'd12,  8'd12,  8'd13,  8'd14,  8'd16,  8'd17,
    8'd19,  8'd21,  8'd24,  8'd26,  8'd29,  8'd32,  8'd36,  8'd39,
    8'd43,  8'd47,  8'd52,  8'd56,  8'd61,  8'd66,  8'd71,  8'd76,
    8'd82,  8'd87,  8'd93,  8'd99,  8'd105, 8'd111, 8'd117, 8'd123,
    8'd129, 8'd135, 8'd141, 8'd147, 8'd153, 8'd159, 8'd165, 8'd170,
    8'd176, 8'd181, 8'd187, 8'd192, 8'd197, 8'd202, 8'd207, 8'd211,
    8'd216, 8'd220, 8'd224, 8'd228, 8'd231, 8'd235, 8'd238, 8'd241,
    8'd244, 8'd246, 8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254
  };

  // Local copy of the modulator state.
  mode_e      mod_mode  = MODE_AM;
  logic [6:0] mod_phase = '0;
  logic [7:0] mod_byte  = '0;
  logic [3:0] mod_left  = '0;

  logic [7:0]  sample_queue[$];
  ctm_result_t wave_expect_q[$];

  int unsigned errors       = 0;
  int unsigned n_requests   = 0;
  int unsigned n_results    = 0;
  int unsigned n_loads      = 0;
  int unsigned n_mode_sets  = 0;
  int unsigned mode_items[4] = '{0, 0, 0, 0};

  bit          req_fired     = 1'b0;
  bit          idle_on       = 1'b1;
  int unsigned gap_left      = 0;
  int unsigned hold_cnt      = 0;
  int unsigned long_hold_ask  = 0;
  int unsigned long_hold_done = 0;

  task automatic report_fail(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advance the model by one sample and return the waveform it gives.
  task automatic modulate(input logic [7:0] s, output ctm_result_t r);
    int         prod;
    int         scaled;
    logic [7:0] sum;
    r.wave       = '0;
    r.byte_taken = 1'b0;
    if (mod_mode == MODE_ASK || mod_mode == MODE_FSK) begin
      if (mod_left == 4'd0) begin
        mod_byte     = s;
        mod_left     = 4'd8;
        r.byte_taken = 1'b1;
      end
    end
    case (mod_mode)
      MODE_AM: begin
        prod      = int'(s) * (int'(CosTable[mod_phase]) - 128);
        scaled    = prod >>> 8;
        r.wave    = 8'(scaled + 127);
        mod_phase = mod_phase + 7'd1;
      end
      MODE_FM: begin
        mod_phase = mod_phase + 7'd1 + 7'(s[7:6]);
        r.wave    = CosTable[mod_phase];
      end
      MODE_ASK: begin
        r.wave    = mod_byte[0] ? CosTable[mod_phase] : 8'd128;
        sum       = {1'b0, mod_phase} + 8'd1;
        mod_phase = sum[6:0];
      end
      default: begin
        sum       = {1'b0, mod_phase} + (mod_byte[0] ? 8'd12 : 8'd1);
        mod_phase = sum[6:0];
        r.wave    = CosTable[mod_phase];
      end
    endcase
    // Shift out the next data bit on a phase wrap.
    if ((mod_mode == MODE_ASK || mod_mode == MODE_FSK) && sum[7]) begin
      mod_byte = mod_byte >> 1;
      if (mod_left != 4'd0) mod_left = mod_left - 4'd1;
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned draw_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sample outputs, check results and record accepted requests.
  always @(posedge clk_i) begin
    ctm_result_t got;
    ctm_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) mod_mode = mode_e'(cfg_wdata_i);
      if (out_valid_o && !out_stall_i) begin
        got.wave       = wave_o;
        got.byte_taken = byte_taken_o;
        if (wave_expect_q.size() == 0) begin
          report_fail($sformatf("unexpected result wave=%0d", got.wave));
        end else begin
          want = wave_expect_q.pop_front();
          n_results++;
          if (got.wave != want.wave)
            report_fail($sformatf("wave got %0d exp %0d", got.wave, want.wave));
          if (got.byte_taken !== want.byte_taken)
            report_fail($sformatf("byte_taken got %b exp %b",
                                  got.byte_taken, want.byte_taken));
        end
      end
      req_fired = in_valid_i && !in_stall_o;
      if (req_fired) begin
        modulate(sample_i, want);
        wave_expect_q.push_back(want);
        n_requests++;
        mode_items[mod_mode]++;
        if (want.byte_taken) n_loads++;
      end
    end else begin
      req_fired = 1'b0;
    end
  end

  // Request driver: hold while stalled, otherwise wait out the gap and send.
  always @(negedge clk_i) begin
    if (in_valid_i && !req_fired) begin
      // hold the stalled request
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (rst_ni && sample_queue.size() != 0) begin
      in_valid_i <= 1'b1;
      sample_i   <= sample_queue.pop_front();
      gap_left   <= draw_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result receiver with random stalls and an on-demand long hold-off.
  always @(negedge clk_i) begin
    int unsigned n;
    if (long_hold_done != long_hold_ask) begin
      long_hold_done <= long_hold_ask;
      hold_cnt       <= 60;
      out_stall_i    <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      n = draw_stall();
      out_stall_i <= (n != 0);
      hold_cnt    <= (n != 0) ? n - 1 : 0;
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (sample_queue.size() != 0 || in_valid_i || wave_expect_q.size() != 0);
  endtask

  task automatic set_mode(input mode_e m);
    wait_drained();
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_mode_sets++;
  endtask

  task automatic push_list(input logic [7:0] vals[]);
    foreach (vals[i]) sample_queue.push_back(vals[i]);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) sample_queue.push_back(pick_sample());
  endtask

  mode_e run_modes[12] = '{MODE_AM, MODE_FSK, MODE_FM, MODE_ASK, MODE_FSK, MODE_ASK,
                           MODE_FM, MODE_AM, MODE_FSK, MODE_FSK, MODE_ASK, MODE_AM};

  initial begin
    int unsigned count;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: amplitude extremes, every FM step, byte loads and wraps.
    set_mode(MODE_AM);
    push_list('{8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80});
    set_mode(MODE_FM);
    push_list('{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF, 8'h3F});
    set_mode(MODE_ASK);
    push_list('{8'hFF, 8'h00, 8'hA5, 8'h5A});
    set_mode(MODE_FSK);
    push_list('{8'h81, 8'hFF, 8'h00, 8'h7E, 8'hFF, 8'h01});

    foreach (run_modes[p]) begin
      set_mode(p == 11 ? mode_e'($urandom_range(0, 3)) : run_modes[p]);
      idle_on = (p == 1) ? 1'b1 : (p == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
      count   = 145 + $urandom_range(0, 20);
      if (p == 4) begin
        // pause the sender until everything in flight has drained
        push_random(count / 2);
        wait_drained();
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        push_random(count - count / 2);
      end else begin
        push_random(count);
        if (p == 1) begin
          @(posedge clk_i);
          #1;
          long_hold_ask++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d mode writes, %0d byte loads",
             n_requests, n_results, n_mode_sets, n_loads);
    $display("per mode: AM %0d  FM %0d  ASK %0d  FSK %0d",
             mode_items[MODE_AM], mode_items[MODE_FM],
             mode_items[MODE_ASK], mode_items[MODE_FSK]);
    if (errors == 0) begin
      $display("PASS cosine_table_modulator_core");
    end else begin
      $display("FAIL cosine_table_modulator_core");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still expected", wave_expect_q.size());
    $display("FAIL cosine_table_modulator_core");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ctm_pkg.sv
hw/rtl/ctm_step.sv
hw/rtl/cosine_table_modulator_core.sv
tb/tb.sv
